FILE: design/pfa_pkg.sv
package pfa_pkg;

    localparam int unsigned FREE_DEPTH = 256;
    localparam int unsigned PAGE_BYTES = 4096;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned IDX_W   = $clog2(FREE_DEPTH);
    localparam int unsigned CNT_W   = $clog2(FREE_DEPTH + 1);
    localparam int unsigned CFG_W   = 2;
    localparam int unsigned STAT_W  = 2;

    // request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_LOW_END    = 2'd0;
    localparam logic [CFG_W-1:0] CFG_HIGH_START = 2'd1;
    localparam logic [CFG_W-1:0] CFG_HIGH_END   = 2'd2;

    localparam logic [ADDR_W-1:0] HIGH_END_RST = 32'd20;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

endpackage

FILE: design/page_frame_allocator.sv
// Page frame allocator. Each input word is a request: tuser = 0 allocates a page,
// tuser = 1 returns the page whose byte address is in tdata. Every request gives
// exactly one output word: tdata is the page address (zero on failure and on every
// free) and tuser the status (0 allocated, 1 out of pages, 2 freed, 3 free list full,
// page dropped). Allocation first walks a bump pointer through the low region, skips
// the hole up to the page-aligned high region start and stops at the high region end;
// after that it pops a first-in-first-out list of returned pages held in a 256-entry
// synchronous memory. Frees and bump allocations are taken back to back while the
// output is drained; a free list allocation goes through the registered memory read
// and S_POP, taking no request meanwhile. The memory needs no clearing pass after
// reset: an entry is only read after it has been written. Configuration is written
// through the cfg channel (0 low region end, 1 high region start, 2 high region end,
// other indexes ignored); the user must not write it while a request is in flight.
module page_frame_allocator
    import pfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [ADDR_W-1:0]    i_s_tdata,   // [31:0] free_page_addr
    input  logic                 i_s_tuser,   // [0] cmd
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [ADDR_W-1:0]    o_m_tdata,   // [31:0] page_addr
    output logic [STAT_W-1:0]    o_m_tuser,   // [1:0] status
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'(PAGE_BYTES - 1);

    // configuration registers
    logic [ADDR_W-1:0] r_low_end;
    logic [ADDR_W-1:0] r_high_start;
    logic [ADDR_W-1:0] r_high_end;
    logic [ADDR_W:0]   r_high_start_rnd;  // high start rounded up to a page, 33 bits
    logic [ADDR_W:0]   w_rnd_sum;

    // allocator state
    t_state            r_state;
    logic [ADDR_W-1:0] r_bump;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_wr_idx;
    logic [CNT_W-1:0]  r_free_cnt;

    // free list memory, read data registered
    logic [ADDR_W-1:0] r_mem [FREE_DEPTH];
    logic [ADDR_W-1:0] r_mem_q;

    // output register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [STAT_W-1:0] r_out_status;

    logic              w_accept;
    logic              w_out_free;
    logic              w_is_alloc;
    logic              w_bump_ok;
    logic              w_list_empty;
    logic              w_list_full;
    logic              w_do_pop;
    logic              w_do_push;
    logic [ADDR_W:0]   w_next_raw;
    logic [ADDR_W:0]   w_next_skip;
    logic [ADDR_W:0]   w_next_sat;
    logic [ADDR_W-1:0] n_bump;

    assign o_cfg_ready = 1'b1;

    // output slot is free, or its word leaves this cycle
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_is_alloc   = (i_s_tuser == CMD_ALLOC);
    assign w_bump_ok    = r_bump < r_high_end;
    assign w_list_empty = (r_free_cnt == '0);
    assign w_list_full  = (r_free_cnt == CNT_W'(FREE_DEPTH));
    assign w_do_pop     = w_accept && w_is_alloc && !w_bump_ok && !w_list_empty;
    assign w_do_push    = w_accept && !w_is_alloc && !w_list_full;

    // next bump value: step one page, jump over the hole, clamp at the region end
    always_comb begin
        w_next_raw = {1'b0, r_bump} + (ADDR_W + 1)'(PAGE_BYTES);
        if (w_next_raw > {1'b0, r_low_end} && w_next_raw < {1'b0, r_high_start}) begin
            w_next_skip = r_high_start_rnd;
        end else begin
            w_next_skip = w_next_raw;
        end
        if (w_next_skip > {1'b0, r_high_end}) begin
            w_next_sat = {1'b0, r_high_end};
        end else begin
            w_next_sat = w_next_skip;
        end
        n_bump = w_next_sat[ADDR_W-1:0];
    end

    // round the written high start up to a page boundary at configuration time
    assign w_rnd_sum = {1'b0, i_cfg_data} + PAGE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_end        <= '0;
            r_high_start     <= '0;
            r_high_start_rnd <= '0;
            r_high_end       <= HIGH_END_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LOW_END: begin
                    r_low_end <= i_cfg_data;
                end
                CFG_HIGH_START: begin
                    r_high_start     <= i_cfg_data;
                    r_high_start_rnd <= w_rnd_sum & ~PAGE_MASK;
                end
                CFG_HIGH_END: begin
                    r_high_end <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // free list memory: one write port for frees, one registered read for pops
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_idx] <= i_s_tdata;
        end
        if (w_do_pop) begin
            r_mem_q <= r_mem[r_rd_idx];
        end
    end

    // control state: sequencer, bump pointer, list pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bump     <= '0;
            r_rd_idx   <= '0;
            r_wr_idx   <= '0;
            r_free_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_do_pop) begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_accept && w_is_alloc && w_bump_ok) begin
                r_bump <= n_bump;
            end
            if (w_do_pop) begin
                r_rd_idx   <= r_rd_idx + IDX_W'(1);
                r_free_cnt <= r_free_cnt - CNT_W'(1);
            end
            if (w_do_push) begin
                r_wr_idx   <= r_wr_idx + IDX_W'(1);
                r_free_cnt <= r_free_cnt + CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_POP) begin
            r_out_valid <= 1'b1;
        end else if (w_accept && !w_do_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_POP) begin
            r_out_addr   <= r_mem_q;
            r_out_status <= ST_ALLOC;
        end else if (w_accept && !w_do_pop) begin
            if (w_is_alloc) begin
                if (w_bump_ok) begin
                    r_out_addr   <= r_bump;
                    r_out_status <= ST_ALLOC;
                end else begin
                    r_out_addr   <= '0;
                    r_out_status <= ST_EMPTY;
                end
            end else begin
                r_out_addr   <= '0;
                r_out_status <= w_list_full ? ST_FULL : ST_FREED;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_addr;
    assign o_m_tuser  = r_out_status;

    // fill count never passes the list depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CNT_W'(FREE_DEPTH))
        else $error("free list count above depth");

    // pointer distance agrees with the fill count
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_idx - r_rd_idx) == r_free_cnt[IDX_W-1:0])
        else $error("free list pointers disagree with count");

    // a pop is only started with a non-empty list
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_pop |-> !w_list_empty && r_state == S_IDLE)
        else $error("pop from empty free list");

    // a pop always delivers its word into the output register next cycle
    a_pop_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> r_out_valid && r_out_status == ST_ALLOC)
        else $error("pop result lost");

endmodule
